@@ sv/key_edge_and_autorepeat_tracker_defines.svh @@
// Assertion macros shared by the key tracker checker.
`ifndef KEY_EDGE_AND_AUTOREPEAT_TRACKER_DEFINES_SVH
`define KEY_EDGE_AND_AUTOREPEAT_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KEAT_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("key tracker check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KEAT_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("key tracker check failed");

`endif

@@ sv/keat_pkg.sv @@
// Shared types and constants of the key edge and auto-repeat tracker.
package keat_pkg;

	localparam int NUM_KEYS  = 32;
	localparam int MASK_BITS = 32;
	localparam int DELAY_W   = 10;
	localparam int KEY_W     = 6;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 136;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [DELAY_W-1:0] delay_t;

	// request kinds carried in tuser
	typedef enum logic [1:0] {
		REQ_LEVEL = 2'd0,
		REQ_PULSE = 2'd1,
		REQ_TICK  = 2'd2
	} req_t;

	// configuration register indexes
	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_NEXT  = 1'b1;

	localparam delay_t FIRST_RST = 10'd20;
	localparam delay_t NEXT_RST  = 10'd4;

	typedef struct packed {
		delay_t first_dly;
		delay_t next_dly;
	} cfg_t;

	typedef struct packed {
		logic set_en;
		logic level;
		logic pulse_en;
	} cell_wr_t;

	typedef struct packed {
		logic held;
		logic press;
		logic rel;
		logic rep;
	} cell_res_t;

endpackage

@@ sv/keat_cell.sv @@
// One key cell: raw level, one-shot flag, latched level and repeat counter.
module keat_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  keat_pkg::cfg_t      cfg,
	input  keat_pkg::cell_wr_t  wr,
	input  logic                tok_in,
	input  logic                any_in,
	output logic                tok_out,
	output logic                any_out,
	output keat_pkg::cell_res_t res
);

	logic                raw_q, pend_q, lat_q, act_q;
	keat_pkg::delay_t    cnt_q;
	logic                tok_q, any_q;
	keat_pkg::cell_res_t res_q;

	logic                cur, pe, re, act_n, trig;
	keat_pkg::delay_t    cnt_n;

	always_comb begin
		cur = raw_q;
		pe  = cur & ~lat_q;
		re  = lat_q & ~cur;
		if (cur) begin
			act_n = 1'b1;
			if (!act_q) begin
				cnt_n = cfg.first_dly;
			end else if (cnt_q == '0) begin
				cnt_n = cfg.next_dly;
			end else begin
				cnt_n = cnt_q - keat_pkg::delay_t'(1);
			end
		end else begin
			act_n = 1'b0;
			cnt_n = '0;
		end
		trig = pe | (act_n & (cnt_n == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q  <= 1'b0;
			pend_q <= 1'b0;
			lat_q  <= 1'b0;
			act_q  <= 1'b0;
			cnt_q  <= '0;
			tok_q  <= 1'b0;
			any_q  <= 1'b0;
			res_q  <= '0;
		end else begin
			tok_q <= tok_in;
			if (tok_in) begin
				lat_q  <= cur;
				// a one-shot press lasts exactly one frame
				if (cur && pend_q) begin
					raw_q <= 1'b0;
				end
				pend_q <= 1'b0;
				act_q  <= act_n;
				cnt_q  <= cnt_n;
				any_q  <= any_in | cur;
				res_q  <= '{held: cur, press: pe, rel: re, rep: trig};
			end else if (wr.pulse_en) begin
				raw_q  <= 1'b1;
				pend_q <= 1'b1;
			end else if (wr.set_en) begin
				raw_q <= wr.level;
			end
		end
	end

	assign tok_out = tok_q;
	assign any_out = any_q;
	assign res     = res_q;

endmodule

@@ sv/key_edge_and_autorepeat_tracker.sv @@
// Top level: input decode, chain of key cells, result word register.
// A tick word is registered in start_q, then its token passes every key cell in turn.
// One tick at a time: the tick token walks the cell chain
//   one key per cycle, and s_axis_tready stays low until the result word is loaded.
// Level and one-shot words are taken one per cycle while no tick is in flight.
// Reset: all keys up and idle, delays 20 and 4, no result word pending.
module key_edge_and_autorepeat_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	// input words
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [keat_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // key[5:0], level[6], zero pad
	input  logic [1:0]                          s_axis_tuser,  // req_type[1:0]
	// result words
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [keat_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // held_mask[31:0],
	                                                           // press_mask[63:32],
	                                                           // release_mask[95:64],
	                                                           // repeat_mask[127:96],
	                                                           // any_held[128], zero pad
	// configuration writes
	input  logic                                wr_en,
	input  logic                                wr_index,
	input  logic [keat_pkg::DELAY_W-1:0]        wr_data
);

	localparam int N = keat_pkg::NUM_KEYS;
	localparam int M = keat_pkg::MASK_BITS;

	// Configuration registers.
	keat_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_dly <= keat_pkg::FIRST_RST;
			cfg_q.next_dly  <= keat_pkg::NEXT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				keat_pkg::CFG_FIRST: cfg_q.first_dly <= wr_data;
				keat_pkg::CFG_NEXT:  cfg_q.next_dly  <= wr_data;
				default: ;
			endcase
		end
	end

	// Input decode. A tick holds the port from acceptance until its result word is
	// loaded into the output register.
	logic              busy_q, start_q, fin_q;
	logic              in_acc, is_tick, is_level, is_pulse;
	keat_pkg::key_t    in_key;
	logic              in_level;

	assign s_axis_tready = ~busy_q;
	assign in_acc   = s_axis_tvalid & s_axis_tready;
	assign in_key   = s_axis_tdata[keat_pkg::KEY_W-1:0];
	assign in_level = s_axis_tdata[keat_pkg::KEY_W];
	assign is_tick  = in_acc & (s_axis_tuser == keat_pkg::REQ_TICK);
	assign is_level = in_acc & (s_axis_tuser == keat_pkg::REQ_LEVEL);
	assign is_pulse = in_acc & (s_axis_tuser == keat_pkg::REQ_PULSE);

	// Cell chain: the token and the running any-held flag hop one cell per cycle.
	logic                tok [0:N];
	logic                anyc [0:N];
	keat_pkg::cell_res_t res [0:N-1];

	assign tok[0]  = start_q;
	assign anyc[0] = 1'b0;

	for (genvar k = 0; k < N; k++) begin : g_cell
		keat_pkg::cell_wr_t wr;
		// keys at or above NUM_KEYS never match, so they drop out here
		assign wr.set_en   = is_level & (in_key == keat_pkg::key_t'(k));
		assign wr.pulse_en = is_pulse & (in_key == keat_pkg::key_t'(k));
		assign wr.level    = in_level;

		keat_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg_q),
			.wr      (wr),
			.tok_in  (tok[k]),
			.any_in  (anyc[k]),
			.tok_out (tok[k+1]),
			.any_out (anyc[k+1]),
			.res     (res[k])
		);
	end

	// Gather per-key bits into masks; keys past the mask width get no bit.
	logic [M-1:0] held_w, press_w, rel_w, rep_w;

	for (genvar b = 0; b < M; b++) begin : g_mask
		if (b < N) begin : g_key
			assign held_w[b]  = res[b].held;
			assign press_w[b] = res[b].press;
			assign rel_w[b]   = res[b].rel;
			assign rep_w[b]   = res[b].rep;
		end else begin : g_pad
			assign held_w[b]  = 1'b0;
			assign press_w[b] = 1'b0;
			assign rel_w[b]   = 1'b0;
			assign rep_w[b]   = 1'b0;
		end
	end

	// Result register. Hold a finished sweep in fin_q while the last word waits.
	logic         out_free, pending, load;
	logic         oval_q;
	logic [M-1:0] held_q, press_q, rel_q, rep_q;
	logic         any_q;

	assign out_free = ~oval_q | m_axis_tready;
	assign pending  = tok[N] | fin_q;
	assign load     = pending & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
			fin_q   <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			start_q <= is_tick;
			fin_q   <= pending & ~out_free;
			if (is_tick) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				oval_q <= 1'b1;
			end else if (m_axis_tready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			held_q  <= held_w;
			press_q <= press_w;
			rel_q   <= rel_w;
			rep_q   <= rep_w;
			any_q   <= anyc[N];
		end
	end

	assign m_axis_tvalid = oval_q;
	assign m_axis_tdata  = {7'd0, any_q, rep_q, rel_q, press_q, held_q};

endmodule

@@ sv/keat_checker.sv @@
// Port-level checks of the key tracker, bound to the top level.
`include "key_edge_and_autorepeat_tracker_defines.svh"

module keat_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [1:0]                      s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [keat_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic                          tick_acc, out_stall;
	logic [keat_pkg::MASK_BITS-1:0] held_m, press_m, rel_m, rep_m;

	assign tick_acc = s_axis_tvalid & s_axis_tready & (s_axis_tuser == keat_pkg::REQ_TICK);
	assign out_stall = m_axis_tvalid & ~m_axis_tready;
	assign held_m  = m_axis_tdata[31:0];
	assign press_m = m_axis_tdata[63:32];
	assign rel_m   = m_axis_tdata[95:64];
	assign rep_m   = m_axis_tdata[127:96];

	// a stalled result word stays put
	`KEAT_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// a tick blocks the input side while its sweep runs
	`KEAT_ASSERT_NXT(a_tick_blocks, tick_acc, !s_axis_tready)

	// a press edge is always held and always fires the repeat trigger
	`KEAT_ASSERT_IMP(a_press_held, m_axis_tvalid, (press_m & ~held_m) == '0)

	`KEAT_ASSERT_IMP(a_press_rep, m_axis_tvalid, (press_m & ~rep_m) == '0)

	// a released key is not held in the same frame
	`KEAT_ASSERT_IMP(a_rel_not_held, m_axis_tvalid, (rel_m & held_m) == '0)

endmodule

bind key_edge_and_autorepeat_tracker keat_checker u_keat_checker (.*);

@@ sim/key_tracker_checker.sv @@
`timescale 1ns / 100ps
// Checker for the key tracker: mirrors key state per frame and compares the mask words.
module key_tracker_checker
	import keat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]            s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  wr_en,
	input  logic                  wr_index,
	input  logic [DELAY_W-1:0]    wr_data,
	output int                    mismatches,
	output int                    masks_owed
);

	localparam int KIDX_W = $clog2(NUM_KEYS);

	typedef struct packed {
		logic [OUT_DATA_W-4*MASK_BITS-2:0] pad;
		logic                              any_held;
		logic [MASK_BITS-1:0]              repeat_mask;
		logic [MASK_BITS-1:0]              release_mask;
		logic [MASK_BITS-1:0]              press_mask;
		logic [MASK_BITS-1:0]              held_mask;
	} frame_masks_t;

	delay_t              first_dly;
	delay_t              next_dly;
	logic [NUM_KEYS-1:0] raw_lvl;
	logic [NUM_KEYS-1:0] shot_pend;
	logic [NUM_KEYS-1:0] latched;
	logic [NUM_KEYS-1:0] rep_idle;
	delay_t              rep_cnt [NUM_KEYS];
	frame_masks_t        owed_masks [$];

	// latch every key, find edges, advance the repeat counters
	function automatic frame_masks_t frame_tick_masks();
		frame_masks_t r;
		logic         was;
		logic         cur;
		logic         rise;
		logic         fall;
		logic         fire;
		r = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			was = latched[k];
			cur = raw_lvl[k];
			rise = cur & ~was;
			fall = was & ~cur;
			latched[k] = cur;
			if (cur) begin
				r.any_held = 1'b1;
				if (shot_pend[k]) begin
					raw_lvl[k] = 1'b0;
					shot_pend[k] = 1'b0;
				end
				if (rep_idle[k]) begin
					rep_idle[k] = 1'b0;
					rep_cnt[k] = first_dly;
				end else if (rep_cnt[k] == '0) begin
					rep_cnt[k] = next_dly;
				end else begin
					rep_cnt[k] = rep_cnt[k] - delay_t'(1);
				end
			end else begin
				shot_pend[k] = 1'b0;
				rep_idle[k] = 1'b1;
				rep_cnt[k] = '0;
			end
			fire = rise | (~rep_idle[k] & (rep_cnt[k] == '0));
			if (k < MASK_BITS) begin
				r.held_mask[k] = cur;
				r.press_mask[k] = rise;
				r.release_mask[k] = fall;
				r.repeat_mask[k] = fire;
			end
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [MASK_BITS-1:0] want,
			input logic [MASK_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		frame_masks_t want;
		frame_masks_t got;
		logic [KEY_W-1:0] key;
		if (!arst_n) begin
			first_dly = FIRST_RST;
			next_dly = NEXT_RST;
			raw_lvl = '0;
			shot_pend = '0;
			latched = '0;
			rep_idle = '1;
			for (int k = 0; k < NUM_KEYS; k++)
				rep_cnt[k] = '0;
			owed_masks.delete();
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_FIRST: first_dly = wr_data;
					CFG_NEXT:  next_dly = wr_data;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				key = s_axis_tdata[KEY_W-1:0];
				case (s_axis_tuser)
					REQ_LEVEL: begin
						if (key < NUM_KEYS)
							raw_lvl[key[KIDX_W-1:0]] = s_axis_tdata[KEY_W];
					end
					REQ_PULSE: begin
						if (key < NUM_KEYS) begin
							raw_lvl[key[KIDX_W-1:0]] = 1'b1;
							shot_pend[key[KIDX_W-1:0]] = 1'b1;
						end
					end
					REQ_TICK: owed_masks.push_back(frame_tick_masks());
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = frame_masks_t'(m_axis_tdata);
				if (owed_masks.size() == 0) begin
					$display("%0t: result word with none expected, got %h", $time,
						m_axis_tdata);
					mismatches++;
				end else begin
					want = owed_masks.pop_front();
					compare_field("held_mask", want.held_mask, got.held_mask);
					compare_field("press_mask", want.press_mask, got.press_mask);
					compare_field("release_mask", want.release_mask, got.release_mask);
					compare_field("repeat_mask", want.repeat_mask, got.repeat_mask);
					compare_field("any_held", MASK_BITS'(want.any_held),
						MASK_BITS'(got.any_held));
				end
			end
		end
		masks_owed = owed_masks.size();
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Top of the key tracker testbench: clock, reset, stimulus, stalls and verdict.
module testbench;
	import keat_pkg::*;

	// request kind that the block must drop without a result
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// a tick walks all keys, plus load and handoff of the result word
	localparam int SETTLE_CYCLES = NUM_KEYS + 4;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 7;
	localparam int PHASE_WORDS = 112;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;  // key[5:0], level[6], zero pad
	logic [1:0]            s_axis_tuser;  // req_type[1:0]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;  // held, press, release, repeat masks, any_held
	logic                  wr_en;
	logic                  wr_index;
	logic [DELAY_W-1:0]    wr_data;
	int                    mismatches;
	int                    masks_owed;
	int                    cycles = 0;
	// while set, neither side inserts gaps or stalls
	bit                    steady = 1'b0;

	always #5 clk = ~clk;

	key_edge_and_autorepeat_tracker u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data)
	);

	key_tracker_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.mismatches    (mismatches),
		.masks_owed    (masks_owed)
	);

	// Offer one input word after a random gap and hold it until taken.
	// Enter and leave at a falling edge; tvalid stays high on return so a
	// back-to-back word never lowers and raises it in one step.
	task automatic send_word(input logic [1:0] req, input logic [KEY_W-1:0] key,
			input logic level);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {1'b0, level, key};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop tvalid, wait out every owed result and any tick still walking the keys.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (masks_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both delays; only called with the block drained.
	task automatic set_delays(input delay_t first_val, input delay_t next_val);
		wr_en <= 1'b1;
		wr_index <= CFG_FIRST;
		wr_data <= first_val;
		@(negedge clk);
		wr_index <= CFG_NEXT;
		wr_data <= next_val;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly ticks and held levels so keys stay down long enough to repeat;
	// some one-shots, out-of-range keys and the unused request kind as noise.
	task automatic random_word();
		int          pick;
		logic [KEY_W-1:0] key;
		pick = $urandom_range(0, 99);
		key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(NUM_KEYS, 63))
		                                  : KEY_W'($urandom_range(0, NUM_KEYS - 1));
		if (pick < 40)
			send_word(REQ_TICK, KEY_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		else if (pick < 75)
			send_word(REQ_LEVEL, key, $urandom_range(0, 3) != 0);
		else if (pick < 95)
			send_word(REQ_PULSE, key, 1'($urandom_range(0, 1)));
		else
			send_word(REQ_UNUSED, key, 1'($urandom_range(0, 1)));
	endtask

	// Result side: stall a random number of cycles before each word.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Hard stop if the block hangs or results never arrive.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("key_edge_and_autorepeat_tracker: mismatch");
			$finish;
		end
	end

	initial begin
		delay_t first_val;
		delay_t next_val;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_LEVEL;
		wr_en = 1'b0;
		wr_index = CFG_FIRST;
		wr_data = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, on the reset delays.
		send_word(REQ_TICK, 6'd0, 1'b0);          // nothing held
		send_word(REQ_LEVEL, 6'd0, 1'b1);         // lowest key
		send_word(REQ_LEVEL, 6'd31, 1'b1);        // highest key
		send_word(REQ_LEVEL, 6'd32, 1'b1);        // out of range, dropped
		send_word(REQ_LEVEL, 6'd63, 1'b1);        // out of range, dropped
		send_word(REQ_TICK, 6'd63, 1'b1);         // press edges on 0 and 31
		send_word(REQ_TICK, 6'd0, 1'b0);          // held, counters run down
		send_word(REQ_PULSE, 6'd5, 1'b0);         // one-frame press
		send_word(REQ_PULSE, 6'd40, 1'b1);        // out of range one-shot
		send_word(REQ_UNUSED, 6'd7, 1'b1);        // unused kind, no result
		send_word(REQ_TICK, 6'd0, 1'b0);          // key 5 press
		send_word(REQ_TICK, 6'd0, 1'b0);          // key 5 release
		send_word(REQ_PULSE, 6'd0, 1'b1);         // one-shot on a held key
		send_word(REQ_TICK, 6'd0, 1'b0);
		send_word(REQ_TICK, 6'd0, 1'b0);          // key 0 drops
		send_word(REQ_LEVEL, 6'd31, 1'b0);
		send_word(REQ_TICK, 6'd0, 1'b0);          // key 31 release
		send_word(REQ_LEVEL, 6'd16, 1'b1);        // up and down between ticks
		send_word(REQ_LEVEL, 6'd16, 1'b0);
		send_word(REQ_LEVEL, 6'd63, 1'b0);
		send_word(REQ_TICK, 6'd0, 1'b0);
		send_word(REQ_TICK, 6'd0, 1'b0);

		// Random phases, each on its own pair of delays, extremes included.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin first_val = 10'd0;    next_val = 10'd0;    end
				1: begin first_val = 10'd1023; next_val = 10'd1023; end
				2: begin first_val = 10'd1;    next_val = 10'd0;    end
				3: begin first_val = 10'd3;    next_val = 10'd2;    end
				4: begin first_val = 10'd0;    next_val = 10'd5;    end
				5: begin
					first_val = delay_t'($urandom_range(0, 12));
					next_val = delay_t'($urandom_range(0, 6));
				end
				default: begin first_val = FIRST_RST; next_val = NEXT_RST; end
			endcase
			drain();
			set_delays(first_val, next_val);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// flip between stretches with gaps and stretches without
				if ($urandom_range(0, 39) == 0)
					steady = ~steady;
				random_word();
			end
		end

		drain();
		if (mismatches == 0)
			$display("key_edge_and_autorepeat_tracker: match");
		else
			$display("key_edge_and_autorepeat_tracker: mismatch");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/keat_pkg.sv
sv/keat_cell.sv
sv/key_edge_and_autorepeat_tracker.sv
sv/keat_checker.sv
sim/key_tracker_checker.sv
sim/testbench.sv
